/* rtl/lpht_pkg.sv */
// Shared types and constants for the linear probe hash table.
package lpht_pkg;

   localparam int KEY_BITS = 64;
   localparam int DATA_BITS = 64;
   localparam int SLOT_BITS = 10;
   localparam int COUNT_BITS = 11;

   localparam logic [2:0] OP_INSERT = 3'd0;
   localparam logic [2:0] OP_REMOVE_KEY = 3'd1;
   localparam logic [2:0] OP_REMOVE_SLOT = 3'd2;
   localparam logic [2:0] OP_LOOKUP = 3'd3;
   localparam logic [2:0] OP_CLEAR = 3'd4;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic [1:0] ST_BAD_SLOT = 2'd3;

   localparam logic [KEY_BITS-1:0] TAG_EMPTY = '0;
   localparam logic [KEY_BITS-1:0] TAG_REMOVED = '1;

   typedef struct packed {
      logic [2:0]            op;
      logic [KEY_BITS-1:0]   key;
      logic [DATA_BITS-1:0]  value_data;
      logic [3:0]            value_bytes;
      logic [SLOT_BITS-1:0]  slot_index;
   } req_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [SLOT_BITS-1:0]  slot_found;
      logic [DATA_BITS-1:0]  value_out;
      logic [COUNT_BITS-1:0] live_entries;
   } rsp_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;        // capture request, start modulo
      logic mod_step;    // one remainder bit
      logic idx_from_mod;
      logic idx_from_slot;
      logic idx_from_clr;
      logic idx_next;    // advance probe index with wrap
      logic idx_inc;     // advance index over the whole table, no wrap
      logic wr_tag;      // write key tag
      logic wr_removed;  // write removed tag
      logic wr_empty;    // write empty tag
      logic wr_value;    // write merged value
      logic cnt_inc;
      logic cnt_dec;
      logic cnt_clr;
      logic emit;
      logic [1:0] emit_status;
      logic emit_slot;   // output slot and value
   } dp_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic [2:0] op;
      logic reserved;
      logic slot_bad;
      logic tag_match;
      logic tag_empty;
      logic tag_removed;
      logic clr_last;
   } dp_stat_type;

endpackage

/* rtl/lpht_ram.sv */
// Generic single-port RAM with registered read.
module lpht_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

/* rtl/lpht_datapath.sv */
// Datapath: request registers, iterative modulo, probe index, stores and count.
module lpht_datapath #(
   parameter int TABLE_DEPTH = 1024,
   parameter int MAX_PROBES = 10,
   parameter int VALUE_BITS = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lpht_pkg::req_type                 req_data,
   input  logic [lpht_pkg::COUNT_BITS-1:0]   size_cfg,
   input  lpht_pkg::dp_cmd_type              cmd,
   output lpht_pkg::dp_stat_type             stat,
   output lpht_pkg::rsp_type                 rsp_data
);
   import lpht_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int SW = $clog2(TABLE_DEPTH + 1) > COUNT_BITS ?
                       $clog2(TABLE_DEPTH + 1) : COUNT_BITS;
   localparam int LO = MAX_PROBES < TABLE_DEPTH ? MAX_PROBES : TABLE_DEPTH;
   localparam int MAXB = VALUE_BITS / 8;

   req_type req_ff;
   logic [SW-1:0] size_ff;
   logic [KEY_BITS-1:0] dvd_ff;
   logic [SW:0] rem_ff, rem_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic [KEY_BITS-1:0] tag_rd, tag_wd;
   logic [VALUE_BITS-1:0] val_rd, val_wd, bmask;
   logic tag_we;
   logic [SW-1:0] size_cfg_x, eff;
   logic [3:0] nbytes;
   logic [SW-1:0] idx_plus;

   assign size_cfg_x = SW'(size_cfg);
   always_comb begin
      eff = size_cfg_x;
      if (size_cfg_x < SW'(LO)) eff = SW'(LO);
      if (size_cfg_x > SW'(TABLE_DEPTH)) eff = SW'(TABLE_DEPTH);
   end

   // Restoring division, one quotient bit per step, remainder kept.
   always_comb begin
      rem_in = {rem_ff[SW-1:0], dvd_ff[KEY_BITS-1]};
      if (rem_in >= {1'b0, size_ff}) rem_in = rem_in - {1'b0, size_ff};
   end

   assign idx_plus = SW'(idx_ff) + SW'(1);

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_from_mod) idx_in = rem_ff[AW-1:0];
      else if (cmd.idx_from_slot) idx_in = AW'(req_ff.slot_index);
      else if (cmd.idx_from_clr) idx_in = '0;
      else if (cmd.idx_inc) idx_in = idx_plus[AW-1:0];
      else if (cmd.idx_next) idx_in = (idx_plus >= size_ff) ? '0 : idx_plus[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
         size_ff <= eff;
         dvd_ff <= req_data.key;
         rem_ff <= '0;
      end else if (cmd.mod_step) begin
         rem_ff <= rem_in;
         dvd_ff <= {dvd_ff[KEY_BITS-2:0], 1'b0};
      end
      idx_ff <= reset ? '0 : idx_in;
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.cnt_clr) cnt_in = '0;
      else if (cmd.cnt_inc) cnt_in = cnt_ff + 1'b1;
      else if (cmd.cnt_dec) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else cnt_ff <= cnt_in;
   end

   always_comb begin
      tag_we = cmd.wr_tag | cmd.wr_removed | cmd.wr_empty;
      tag_wd = cmd.wr_tag ? req_ff.key : (cmd.wr_removed ? TAG_REMOVED : TAG_EMPTY);
   end

   always_comb begin
      nbytes = (req_ff.value_bytes > 4'(MAXB)) ? 4'(MAXB) : req_ff.value_bytes;
      for (int b = 0; b < MAXB; b++) begin
         bmask[b*8 +: 8] = (4'(b) < nbytes) ? 8'hFF : 8'h00;
      end
      val_wd = (val_rd & ~bmask) | (req_ff.value_data[VALUE_BITS-1:0] & bmask);
   end

   lpht_ram #(.WIDTH(KEY_BITS), .DEPTH(TABLE_DEPTH)) u_tag (
      .clock(clock), .we(tag_we), .addr(idx_ff), .wdata(tag_wd), .rdata(tag_rd)
   );
   lpht_ram #(.WIDTH(VALUE_BITS), .DEPTH(TABLE_DEPTH)) u_val (
      .clock(clock), .we(cmd.wr_value), .addr(idx_ff), .wdata(val_wd), .rdata(val_rd)
   );

   always_comb begin
      stat.op = req_ff.op;
      stat.reserved = (req_ff.key == TAG_EMPTY) || (req_ff.key == TAG_REMOVED);
      stat.slot_bad = SW'(req_ff.slot_index) >= size_ff;
      stat.tag_match = tag_rd == req_ff.key;
      stat.tag_empty = tag_rd == TAG_EMPTY;
      stat.tag_removed = tag_rd == TAG_REMOVED;
      stat.clr_last = idx_ff == AW'(TABLE_DEPTH - 1);
   end

   // The value output shows the merged word on insert, the stored word otherwise.
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data.status <= cmd.emit_status;
         rsp_data.slot_found <= cmd.emit_slot ? SLOT_BITS'(idx_ff) : '0;
         rsp_data.value_out <= cmd.emit_slot ?
            DATA_BITS'(cmd.wr_value ? val_wd : val_rd) : '0;
         rsp_data.live_entries <= cnt_in;
      end
   end
endmodule

/* rtl/lpht_ctrl.sv */
// Controller state machine sequencing modulo, probes, writes and clear.
module lpht_ctrl #(
   parameter int MAX_PROBES = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output logic                  rsp_valid,
   input  lpht_pkg::dp_stat_type stat,
   output lpht_pkg::dp_cmd_type  cmd
);
   import lpht_pkg::*;

   localparam int PW = $clog2(MAX_PROBES + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_MOD, S_RD, S_CHK, S_SLOT, S_CLR, S_DONE
   } state_type;

   state_type state_ff;
   logic [6:0] mcnt_ff;
   logic [PW-1:0] pcnt_ff;
   logic busy_ff, valid_ff;
   logic init_ff;
   logic dispatch;
   logic early;
   logic [1:0] early_status;

   assign busy = busy_ff;
   assign rsp_valid = valid_ff;
   assign dispatch = mcnt_ff == 7'd64;

   // Requests that finish at dispatch: reserved key, bad slot, undefined op.
   always_comb begin
      early = 1'b1;
      early_status = ST_OK;
      unique case (stat.op)
         OP_CLEAR: early = 1'b0;
         OP_REMOVE_SLOT: begin
            early = stat.slot_bad;
            early_status = ST_BAD_SLOT;
         end
         OP_INSERT, OP_REMOVE_KEY, OP_LOOKUP: begin
            early = stat.reserved;
            early_status = ST_NOT_FOUND;
         end
         default: ;
      endcase
   end

   // Commands follow the state combinationally; the state advances in the registered block below.
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         S_IDLE: cmd.load = start;
         S_MOD: cmd.mod_step = 1'b1;
         S_RD: ;
         S_CHK: begin
            if (stat.op == OP_INSERT) begin
               if (stat.tag_match || stat.tag_empty || stat.tag_removed) begin
                  cmd.wr_tag = 1'b1;
                  cmd.wr_value = 1'b1;
                  cmd.cnt_inc = !stat.tag_match;
                  cmd.emit = 1'b1;
                  cmd.emit_status = ST_OK;
                  cmd.emit_slot = 1'b1;
               end else if (pcnt_ff == PW'(MAX_PROBES - 1)) begin
                  cmd.emit = 1'b1;
                  cmd.emit_status = ST_FULL;
               end else begin
                  cmd.idx_next = 1'b1;
               end
            end else if (stat.tag_match) begin
               cmd.wr_removed = stat.op == OP_REMOVE_KEY;
               cmd.cnt_dec = stat.op == OP_REMOVE_KEY;
               cmd.emit = 1'b1;
               cmd.emit_status = ST_OK;
               cmd.emit_slot = 1'b1;
            end else if (stat.tag_empty || pcnt_ff == PW'(MAX_PROBES - 1)) begin
               cmd.emit = 1'b1;
               cmd.emit_status = ST_NOT_FOUND;
            end else begin
               cmd.idx_next = 1'b1;
            end
         end
         S_SLOT: begin
            cmd.emit = 1'b1;
            if (stat.tag_empty || stat.tag_removed) begin
               cmd.emit_status = ST_NOT_FOUND;
            end else begin
               cmd.wr_removed = 1'b1;
               cmd.cnt_dec = 1'b1;
               cmd.emit_status = ST_OK;
               cmd.emit_slot = 1'b1;
            end
         end
         S_CLR: begin
            cmd.wr_empty = 1'b1;
            cmd.idx_inc = 1'b1;
            // The clearing pass after reset produces no result.
            if (stat.clr_last) begin
               cmd.cnt_clr = 1'b1;
               cmd.emit = !init_ff;
               cmd.emit_status = ST_OK;
            end
         end
         S_DONE: begin
            if (dispatch) begin
               if (early) begin
                  cmd.emit = 1'b1;
                  cmd.emit_status = early_status;
               end else if (stat.op == OP_CLEAR) begin
                  cmd.idx_from_clr = 1'b1;
               end else if (stat.op == OP_REMOVE_SLOT) begin
                  cmd.idx_from_slot = 1'b1;
               end else begin
                  cmd.idx_from_mod = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         busy_ff <= 1'b1;
         init_ff <= 1'b1;
         valid_ff <= 1'b0;
         mcnt_ff <= '0;
         pcnt_ff <= '0;
      end else begin
         valid_ff <= cmd.emit;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  busy_ff <= 1'b1;
                  mcnt_ff <= '0;
                  pcnt_ff <= '0;
                  state_ff <= S_MOD;
               end
            end
            S_MOD: begin
               mcnt_ff <= mcnt_ff + 7'd1;
               if (mcnt_ff == 7'd63) state_ff <= S_DONE;
            end
            S_RD: state_ff <= (stat.op == OP_REMOVE_SLOT) ? S_SLOT : S_CHK;
            S_CHK: begin
               pcnt_ff <= pcnt_ff + 1'b1;
               state_ff <= cmd.emit ? S_DONE : S_RD;
            end
            S_SLOT: state_ff <= S_DONE;
            S_CLR: begin
               if (stat.clr_last) begin
                  init_ff <= 1'b0;
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               // After the modulo, dispatch on the op; otherwise finish.
               if (dispatch) begin
                  mcnt_ff <= '0;
                  if (early) begin
                     state_ff <= S_IDLE;
                     busy_ff <= 1'b0;
                  end else if (stat.op == OP_CLEAR) begin
                     state_ff <= S_CLR;
                  end else begin
                     state_ff <= S_RD;
                  end
               end else begin
                  state_ff <= S_IDLE;
                  busy_ff <= 1'b0;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   property p_valid_busy;
      @(posedge clock) disable iff (reset) rsp_valid |-> $past(busy_ff);
   endproperty
   a_valid_busy: assert property (p_valid_busy) else $error("strobe outside an operation");

   property p_no_start_busy;
      @(posedge clock) disable iff (reset) busy_ff |-> !cmd.load;
   endproperty
   a_no_start_busy: assert property (p_no_start_busy) else $error("load while busy");

   property p_probe_bound;
      @(posedge clock) disable iff (reset) state_ff == S_CHK |-> pcnt_ff < PW'(MAX_PROBES);
   endproperty
   a_probe_bound: assert property (p_probe_bound) else $error("probe limit passed");
endmodule

/* rtl/linear_probe_hash_table_top.sv */
// Top level of the linear probe hash table: controller, datapath and CSR.
// Every request runs the 64-step bit-serial modulo first; a reserved key, bad slot or
// undefined op then finishes with no table access; insert, remove by key and lookup probe
// up to MAX_PROBES slots; remove by slot reads one slot; clear empties every tag. One
// operation at a time; busy drops in the cycle after the result strobe, or with it for an early finish.
// Synchronous reset sets the size to 1024, zeroes the count, then clears all tags with
// busy high.
module linear_probe_hash_table_top #(
   parameter int TABLE_DEPTH = 1024,
   parameter int MAX_PROBES = 10,
   parameter int VALUE_BITS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  lpht_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   output lpht_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lpht_pkg::COUNT_BITS-1:0]     csr_data
);
   import lpht_pkg::*;

   logic [COUNT_BITS-1:0] size_ff;
   dp_cmd_type cmd;
   dp_stat_type stat;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) size_ff <= COUNT_BITS'(1024);
      else if (csr_valid && csr_ready) size_ff <= csr_data;
   end

   lpht_ctrl #(.MAX_PROBES(MAX_PROBES)) u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .rsp_valid(rsp_valid), .stat(stat), .cmd(cmd)
   );

   lpht_datapath #(
      .TABLE_DEPTH(TABLE_DEPTH), .MAX_PROBES(MAX_PROBES), .VALUE_BITS(VALUE_BITS)
   ) u_dp (
      .clock(clock), .reset(reset), .req_data(req_data), .size_cfg(size_ff),
      .cmd(cmd), .stat(stat), .rsp_data(rsp_data)
   );
endmodule

/* dv/linear_probe_hash_table_top_tb.sv */
// Testbench for the linear probe hash table: directed and random operations with a table predictor.
module linear_probe_hash_table_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lpht_pkg::*;

   localparam int DEPTH = 1024;
   localparam int PROBES = 10;
   localparam logic [2:0] OP_SPARE_LO = 3'd5;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [COUNT_BITS-1:0] csr_data = '0;

   // Predicted table contents, kept in step with accepted transfers.
   logic [KEY_BITS-1:0] tag_mem [DEPTH];
   logic [DATA_BITS-1:0] val_mem [DEPTH];
   bit val_known [DEPTH];
   int live_count;
   int size_reg;
   rsp_type expected_rsp_q[$];
   int error_count = 0;
   bit no_gaps = 1'b0;
   logic [KEY_BITS-1:0] key_pool [24];

   linear_probe_hash_table_top i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic int table_size();
      int s;
      s = size_reg;
      if (s < PROBES) s = PROBES;
      if (s > DEPTH) s = DEPTH;
      return s;
   endfunction

   function automatic logic [KEY_BITS-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Computes the response of one request and updates the table. A partial
   // insert into a slot whose value was never written is widened to a full
   // word, since those bytes are undefined in hardware.
   task automatic predict_table(inout req_type r, output rsp_type e);
      int sz, idx, n;
      logic [KEY_BITS-1:0] t;
      logic [DATA_BITS-1:0] bm;
      bit hit;
      sz = table_size();
      e = '0;
      hit = 1'b0;
      idx = int'(r.key % sz);
      if (r.op == OP_CLEAR) begin
         foreach (tag_mem[i]) tag_mem[i] = TAG_EMPTY;
         live_count = 0;
      end else if (r.op == OP_REMOVE_SLOT) begin
         if (r.slot_index >= sz) begin
            e.status = ST_BAD_SLOT;
         end else if (tag_mem[r.slot_index] == TAG_EMPTY ||
                      tag_mem[r.slot_index] == TAG_REMOVED) begin
            e.status = ST_NOT_FOUND;
         end else begin
            tag_mem[r.slot_index] = TAG_REMOVED;
            live_count--;
            e.slot_found = r.slot_index;
            e.value_out = val_mem[r.slot_index];
         end
      end else if (r.op >= OP_SPARE_LO) begin
         e.status = ST_OK;
      end else if (r.key == TAG_EMPTY || r.key == TAG_REMOVED) begin
         e.status = ST_NOT_FOUND;
      end else begin
         for (int p = 0; p < PROBES && !hit; p++) begin
            t = tag_mem[idx];
            if (r.op == OP_INSERT) begin
               if (t == r.key || t == TAG_EMPTY || t == TAG_REMOVED) begin
                  if (!val_known[idx] && r.value_bytes < 8) r.value_bytes = 4'd8;
                  n = (r.value_bytes > 8) ? 8 : r.value_bytes;
                  bm = (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
                  val_mem[idx] = (val_mem[idx] & ~bm) | (r.value_data & bm);
                  if (n > 0) val_known[idx] = 1'b1;
                  if (t != r.key) live_count++;
                  tag_mem[idx] = r.key;
                  hit = 1'b1;
               end
            end else if (t == r.key) begin
               if (r.op == OP_REMOVE_KEY) begin
                  tag_mem[idx] = TAG_REMOVED;
                  live_count--;
               end
               hit = 1'b1;
            end else if (t == TAG_EMPTY) begin
               p = PROBES;
            end
            if (hit) begin
               e.slot_found = SLOT_BITS'(idx);
               e.value_out = val_mem[idx];
            end else begin
               idx = (idx + 1 >= sz) ? 0 : idx + 1;
            end
         end
         if (!hit) e.status = (r.op == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
      end
      e.live_entries = COUNT_BITS'(live_count);
   endtask

   task automatic send_request(req_type r);
      rsp_type e;
      while (!no_gaps && $urandom_range(99) < 22) begin
         @(negedge clock);
         start = 1'b0;
      end
      predict_table(r, e);
      expected_rsp_q.push_back(e);
      @(negedge clock);
      start = 1'b1;
      req_data = r;
      do @(posedge clock); while (busy);
   endtask

   task automatic send_op(logic [2:0] op, logic [KEY_BITS-1:0] key,
                          logic [DATA_BITS-1:0] data = '1, logic [3:0] nbytes = 4'd8,
                          logic [SLOT_BITS-1:0] slot = '0);
      req_type r;
      r.op = op;
      r.key = key;
      r.value_data = data;
      r.value_bytes = nbytes;
      r.slot_index = slot;
      send_request(r);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      start = 1'b0;
      wait (expected_rsp_q.size() == 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_size(logic [COUNT_BITS-1:0] value);
      wait_idle();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      size_reg = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Keys clustered around a few home slots so that probe chains form.
   task automatic fill_key_pool();
      int sz;
      logic [KEY_BITS-1:0] k;
      sz = table_size();
      foreach (key_pool[i]) begin
         if ($urandom_range(5) == 0)
            k = rand64();
         else
            k = (rand64() >> 12) * sz + $urandom_range(3) + 4 * $urandom_range(2);
         if (k == TAG_EMPTY || k == TAG_REMOVED) k = 64'd1;
         key_pool[i] = k;
      end
   endtask

   task automatic test_directed();
      int sz;
      send_op(OP_CLEAR, '0);
      send_op(OP_INSERT, 64'd5, '1, 4'd8);
      send_op(OP_INSERT, 64'd5, 64'h0123_4567_89AB_CDEF, 4'd3);
      send_op(OP_INSERT, 64'd5, 64'hAAAA_AAAA_AAAA_AAAA, 4'd0);
      send_op(OP_INSERT, 64'd1029, 64'h5555_5555_5555_5555, 4'd15);
      send_op(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFE, '0, 4'd8);
      send_op(OP_LOOKUP, 64'd1029);
      send_op(OP_LOOKUP, 64'd2053);
      send_op(OP_INSERT, TAG_EMPTY);
      send_op(OP_LOOKUP, TAG_REMOVED);
      send_op(OP_REMOVE_KEY, TAG_EMPTY);
      send_op(OP_REMOVE_KEY, 64'd5);
      send_op(OP_LOOKUP, 64'd1029);
      send_op(OP_REMOVE_KEY, 64'd5);
      send_op(OP_REMOVE_SLOT, '0, '0, 4'd0, 10'd6);
      send_op(OP_REMOVE_SLOT, '0, '0, 4'd0, 10'd1023);
      send_op(OP_REMOVE_SLOT, '0, '0, 4'd0, 10'd6);
      send_op(OP_SPARE_LO, 64'd1029);
      send_op(OP_SPARE_HI, '1, '1, 4'd15, '1);
      // A size below the probe limit saturates; the eleventh colliding key is full.
      write_size(11'd3);
      sz = table_size();
      send_op(OP_CLEAR, '0);
      for (int i = 0; i <= PROBES; i++) send_op(OP_INSERT, 64'd7 + i * sz, rand64(), 4'd8);
      send_op(OP_REMOVE_SLOT, '0, '0, 4'd0, 10'd10);
      send_op(OP_REMOVE_SLOT, '0, '0, 4'd0, 10'd4);
      send_op(OP_INSERT, 64'd7 + 20 * sz, rand64(), 4'd2);
   endtask

   task automatic random_phase(int count);
      req_type r;
      int sz, pick;
      fill_key_pool();
      sz = table_size();
      for (int n = 0; n < count; n++) begin
         r.value_data = rand64();
         r.value_bytes = 4'($urandom_range(15));
         r.slot_index = SLOT_BITS'(($urandom_range(1)) ? $urandom_range(sz - 1) :
                                                         $urandom_range(1023));
         r.key = key_pool[$urandom_range(23)];
         pick = $urandom_range(99);
         if (pick < 40) r.op = OP_INSERT;
         else if (pick < 55) r.op = OP_REMOVE_KEY;
         else if (pick < 65) r.op = OP_REMOVE_SLOT;
         else if (pick < 91) r.op = OP_LOOKUP;
         else if (pick < 93) r.op = OP_CLEAR;
         else if (pick < 96) r.op = 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
         else begin
            r.op = 3'($urandom_range(OP_LOOKUP));
            r.key = ($urandom_range(1)) ? TAG_EMPTY : TAG_REMOVED;
         end
         if ($urandom_range(9) == 0) r.key = rand64();
         send_request(r);
      end
   endtask

   task automatic test_random();
      random_phase(250);
      write_size(11'd10);
      random_phase(150);
      no_gaps = 1'b1;
      write_size(11'd2047);
      random_phase(150);
      no_gaps = 1'b0;
      write_size(11'd0);
      random_phase(100);
      write_size(11'd1024);
      random_phase(100);
      write_size(11'($urandom_range(1023, 11)));
      random_phase(170);
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid) begin
         if (expected_rsp_q.size() == 0) begin
            $error("unexpected response %p", rsp_data);
            error_count++;
         end else begin
            e = expected_rsp_q.pop_front();
            if (rsp_data.status !== e.status) begin
               $error("status: expected %0d, got %0d", e.status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.slot_found !== e.slot_found) begin
               $error("slot_found: expected %0d, got %0d", e.slot_found, rsp_data.slot_found);
               error_count++;
            end
            if (rsp_data.value_out !== e.value_out) begin
               $error("value_out: expected %h, got %h", e.value_out, rsp_data.value_out);
               error_count++;
            end
            if (rsp_data.live_entries !== e.live_entries) begin
               $error("live_entries: expected %0d, got %0d", e.live_entries,
                      rsp_data.live_entries);
               error_count++;
            end
         end
      end
   end

   initial begin
      foreach (tag_mem[i]) begin
         tag_mem[i] = TAG_EMPTY;
         val_mem[i] = '0;
         val_known[i] = 1'b0;
      end
      live_count = 0;
      size_reg = 1024;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random();
      wait_idle();
      repeat (1200) @(posedge clock);
      if (error_count == 0 && expected_rsp_q.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
